### rtl/epg_pkg.sv
`default_nettype none
package epg_pkg;

  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned ISQRT_STEPS  = 32;
  localparam int unsigned NDIV_STEPS   = 74;
  localparam int unsigned GDIV_STEPS   = 32;
  localparam int unsigned A_SHIFT      = 47;

  localparam logic [1:0] REG_GRAV_PARAM      = 2'd0;
  localparam logic [1:0] REG_SEMI_MAJOR_AXIS = 2'd1;
  localparam logic [1:0] REG_ECCENTRICITY    = 2'd2;

  localparam logic [56:0] GRAV_PARAM_RST      = 57'd398600441800000;
  localparam logic [26:0] SEMI_MAJOR_AXIS_RST = 27'd6378137;
  localparam logic [31:0] ECCENTRICITY_RST    = 32'd351410750;

  localparam logic signed [26:0] TURN_UNITS    = 27'sd23592960;
  localparam logic signed [26:0] HALF_UNITS    = 27'sd11796480;
  localparam logic signed [26:0] QUARTER_UNITS = 27'sd5898240;

  localparam logic [40:0] RAD_SCALE = 41'd1228166276394;
  localparam logic [19:0] RS_LO     = RAD_SCALE[19:0];
  localparam logic [20:0] RS_HI     = RAD_SCALE[40:20];

  localparam logic [33:0] CORDIC_X0 = 34'd652032874;
  localparam logic [33:0] ONE_Q30   = 34'd1073741824;
  localparam logic [31:0] GRAVITY_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [33:0] x;
    logic [33:0] y;
    logic [32:0] z;
  } rot_t;

  typedef struct packed {
    rot_t        lat;
    rot_t        lon;
    logic [30:0] alt;
  } cor_t;

  typedef struct packed {
    logic [30:0] sl;
    logic [30:0] cl;
    logic [30:0] so;
    logic [30:0] co;
    logic [30:0] alt;
  } trig_t;

  typedef struct packed {
    trig_t       tr;
    logic [62:0] v;
    logic [62:0] r;
  } isq_t;

  typedef struct packed {
    trig_t       tr;
    logic [31:0] s;
    logic [31:0] r;
    logic [58:0] q;
  } ndv_t;

  typedef struct packed {
    logic         sat;
    logic [121:0] d;
    logic [121:0] r;
    logic [31:0]  q;
  } gdv_t;

  function automatic logic [31:0] atan_rom(int unsigned i);
    logic [31:0] v;
    unique case (i)
      0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
      24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
      27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // fold an angle into [0, 90] degrees, keeping |sin| and |cos|
  function automatic logic [22:0] fold_angle(logic signed [26:0] a);
    logic signed [26:0] t;
    t = a;
    if (t < 0) t = t + TURN_UNITS;
    if (t >= HALF_UNITS) t = t - HALF_UNITS;
    if (t > QUARTER_UNITS) t = HALF_UNITS - t;
    return t[22:0];
  endfunction

  function automatic rot_t rot_step(rot_t a, int unsigned i);
    rot_t o;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic [32:0] at;
    dx = $signed(a.y) >>> i;
    dy = $signed(a.x) >>> i;
    at = {1'b0, atan_rom(i)};
    if (!a.z[32]) begin
      o.x = a.x - dx;
      o.y = a.y + dy;
      o.z = a.z - at;
    end else begin
      o.x = a.x + dx;
      o.y = a.y - dy;
      o.z = a.z + at;
    end
    return o;
  endfunction

  function automatic logic [30:0] clamp_q30(logic [33:0] v);
    logic [30:0] o;
    if (v[33]) o = '0;
    else if (v > ONE_Q30) o = ONE_Q30[30:0];
    else o = v[30:0];
    return o;
  endfunction

  function automatic isq_t isq_step(isq_t a, int unsigned k);
    isq_t o;
    logic [62:0] b;
    logic [63:0] sum;
    o = a;
    b = 63'(1) << (62 - 2 * k);
    sum = {1'b0, a.r} + {1'b0, b};
    if ({1'b0, a.v} >= sum) begin
      o.v = a.v - sum[62:0];
      o.r = (a.r >> 1) + b;
    end else begin
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  function automatic ndv_t ndv_step(ndv_t a, logic nbit);
    ndv_t o;
    logic [32:0] sh;
    logic [32:0] df;
    o = a;
    sh = {a.r, nbit};
    df = sh - {1'b0, a.s};
    if (sh >= {1'b0, a.s}) begin
      o.r = df[31:0];
      o.q = {a.q[57:0], 1'b1};
    end else begin
      o.r = sh[31:0];
      o.q = {a.q[57:0], 1'b0};
    end
    return o;
  endfunction

  function automatic gdv_t gdv_step(gdv_t a);
    gdv_t o;
    logic [122:0] sh;
    logic [122:0] df;
    o = a;
    sh = {a.r, 1'b0};
    df = sh - {1'b0, a.d};
    if (sh >= {1'b0, a.d}) begin
      o.r = df[121:0];
      o.q = {a.q[30:0], 1'b1};
    end else begin
      o.r = sh[121:0];
      o.q = {a.q[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic signed [60:0] alt_q16(logic [30:0] alt);
    return {{14{alt[30]}}, alt, 16'b0};
  endfunction

endpackage
`default_nettype wire

### rtl/ellipsoid_point_gravity.sv
// Point-mass gravity GM/r^2 at a geodetic point, one request per clock cycle while the output is not stalled.
// Each request passes a fixed pipeline of 185 register stages: two 30-step CORDIC
// lanes, a 32-step square root and two restoring dividers (74 and 32 steps), one step
// per stage, plus split multiplier stages. The whole pipeline holds while the output
// register is full and not taken. Configuration registers are read at several stages, so
// a write also reaches requests already in flight; write them only while the pipeline is empty.
`default_nettype none
module ellipsoid_point_gravity (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,   // altitude[30:0], latitude[54:31], longitude[79:55]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // gravity[31:0]
  output logic             m_axis_tuser,   // saturated[0]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [56:0] cfg_data_i
);
  import epg_pkg::*;

  localparam int unsigned ST_COR = 2;
  localparam int unsigned ST_ISQ = ST_COR + CORDIC_STEPS + 3;
  localparam int unsigned ST_NDV = ST_ISQ + ISQRT_STEPS + 1;
  localparam int unsigned ST_M   = ST_NDV + NDIV_STEPS + 1;
  localparam int unsigned ST_GDV = ST_M + 8;
  localparam int unsigned N_ST   = ST_GDV + GDIV_STEPS + 2;

  logic [56:0] gm_q;
  logic [26:0] a_q;
  logic [31:0] ecc_q;
  logic [32:0] om_q;
  logic [63:0] e2_p;
  logic [80:0] gm_sh;

  logic             adv;
  logic [N_ST-1:0]  vld_q;

  assign adv           = !vld_q[N_ST-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[N_ST-1];
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gm_q  <= GRAV_PARAM_RST;
      a_q   <= SEMI_MAJOR_AXIS_RST;
      ecc_q <= ECCENTRICITY_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GRAV_PARAM:      gm_q  <= cfg_data_i;
        REG_SEMI_MAJOR_AXIS: a_q   <= cfg_data_i[26:0];
        REG_ECCENTRICITY:    ecc_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign e2_p  = 64'(ecc_q) * 64'(ecc_q);
  assign gm_sh = {gm_q, 24'b0};

  always_ff @(posedge clk_i) begin
    om_q <= 33'h1_0000_0000 - {1'b0, e2_p[63:32]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[N_ST-2:0], s_axis_tvalid};
    end
  end

  // angle folding and radian scaling
  logic [22:0] f0_tl_q, f0_to_q;
  logic [30:0] f0_alt_q, f1_alt_q;
  logic [42:0] f1_llo_q, f1_olo_q;
  logic [43:0] f1_lhi_q, f1_ohi_q;
  logic [63:0] f2_zl, f2_zo;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f0_tl_q  <= fold_angle({{3{s_axis_tdata[54]}}, s_axis_tdata[54:31]});
      f0_to_q  <= fold_angle({{2{s_axis_tdata[79]}}, s_axis_tdata[79:55]});
      f0_alt_q <= s_axis_tdata[30:0];
      f1_llo_q <= 43'(f0_tl_q) * 43'(RS_LO);
      f1_lhi_q <= 44'(f0_tl_q) * 44'(RS_HI);
      f1_olo_q <= 43'(f0_to_q) * 43'(RS_LO);
      f1_ohi_q <= 44'(f0_to_q) * 44'(RS_HI);
      f1_alt_q <= f0_alt_q;
    end
  end

  assign f2_zl = {f1_lhi_q, 20'b0} + 64'(f1_llo_q);
  assign f2_zo = {f1_ohi_q, 20'b0} + 64'(f1_olo_q);

  cor_t cor_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cor_q[0].lat <= '{x: CORDIC_X0, y: '0, z: {1'b0, f2_zl[63:32]}};
      cor_q[0].lon <= '{x: CORDIC_X0, y: '0, z: {1'b0, f2_zo[63:32]}};
      cor_q[0].alt <= f1_alt_q;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cor_q[k+1].lat <= rot_step(cor_q[k].lat, k);
        cor_q[k+1].lon <= rot_step(cor_q[k].lon, k);
        cor_q[k+1].alt <= cor_q[k].alt;
      end
    end
  end

  // prime-vertical radius terms
  trig_t       e1_tr_q, e2_tr_q;
  logic [62:0] e1_esp_q;
  logic [63:0] e2_es2_q;
  logic [31:0] e2_es;
  logic [32:0] e3_d;
  isq_t        isq_q [ISQRT_STEPS+1];
  ndv_t        ndv_q [NDIV_STEPS+1];
  logic [NDIV_STEPS-1:0] nbit;
  trig_t       c_tr;

  assign c_tr = '{sl: clamp_q30(cor_q[CORDIC_STEPS].lat.y),
                  cl: clamp_q30(cor_q[CORDIC_STEPS].lat.x),
                  so: clamp_q30(cor_q[CORDIC_STEPS].lon.y),
                  co: clamp_q30(cor_q[CORDIC_STEPS].lon.x),
                  alt: cor_q[CORDIC_STEPS].alt};
  assign e2_es = e1_esp_q[61:30];
  assign e3_d  = 33'h1_0000_0000 - {1'b0, e2_es2_q[63:32]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_tr_q  <= c_tr;
      e1_esp_q <= 63'(ecc_q) * 63'(c_tr.sl);
      e2_tr_q  <= e1_tr_q;
      e2_es2_q <= 64'(e2_es) * 64'(e2_es);
      isq_q[0] <= '{tr: e2_tr_q, v: {e3_d, 30'b0}, r: '0};
    end
  end

  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_isq
    always_ff @(posedge clk_i) begin
      if (adv) isq_q[k+1] <= isq_step(isq_q[k], k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ndv_q[0].tr <= isq_q[ISQRT_STEPS].tr;
      ndv_q[0].s  <= (isq_q[ISQRT_STEPS].r[31:0] == '0) ? 32'd1
                                                        : isq_q[ISQRT_STEPS].r[31:0];
      ndv_q[0].r  <= '0;
      ndv_q[0].q  <= '0;
    end
  end

  for (genvar j = 0; j < NDIV_STEPS; j++) begin : g_ndv
    localparam int unsigned NB = NDIV_STEPS - 1 - j;
    if (NB >= A_SHIFT) begin : g_abit
      assign nbit[j] = a_q[NB-A_SHIFT];
    end else begin : g_zbit
      assign nbit[j] = 1'b0;
    end
    always_ff @(posedge clk_i) begin
      if (adv) ndv_q[j+1] <= ndv_step(ndv_q[j], nbit[j]);
    end
  end

  // Cartesian terms and r^2
  trig_t        m1_tr_q, m2_tr_q, m3_tr_q;
  logic [62:0]  m1_nlo_q;
  logic [61:0]  m1_nhi_q;
  logic [59:0]  m1_pm_q, m3_qm_q, m3_rho_q;
  logic [58:0]  m2_nb_q;
  logic [60:0]  m2_rlo_q, m2_rhi_q;
  logic [60:0]  m4_zlo_q, m4_zhi_q, m4_xlo_q, m4_xhi_q, m4_ylo_q, m4_yhi_q;
  logic [2:0][59:0]  m5_v_q, m6_ll_q, m6_hl_q, m6_hh_q;
  logic [2:0][119:0] m7_sq_q;
  logic [121:0] m8_r2_q;
  logic signed [60:0] m1_p, m3_p;
  logic [91:0]  m2_sum;
  logic [58:0]  m1_n;
  gdv_t         gdv_q [GDIV_STEPS+1];

  assign m1_n   = ndv_q[NDIV_STEPS].q;
  assign m1_p   = $signed({2'b0, m1_n}) + alt_q16(ndv_q[NDIV_STEPS].tr.alt);
  assign m2_sum = {m1_nhi_q, 30'b0} + 92'(m1_nlo_q);
  assign m3_p   = $signed({2'b0, m2_nb_q}) + alt_q16(m2_tr_q.alt);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_tr_q  <= ndv_q[NDIV_STEPS].tr;
      m1_nlo_q <= 63'(m1_n[29:0]) * 63'(om_q);
      m1_nhi_q <= 62'(m1_n[58:30]) * 62'(om_q);
      m1_pm_q  <= m1_p[60] ? 60'(-m1_p) : m1_p[59:0];

      m2_tr_q  <= m1_tr_q;
      m2_nb_q  <= m2_sum[90:32];
      m2_rlo_q <= 61'(m1_pm_q[29:0]) * 61'(m1_tr_q.cl);
      m2_rhi_q <= 61'(m1_pm_q[59:30]) * 61'(m1_tr_q.cl);

      m3_tr_q  <= m2_tr_q;
      m3_qm_q  <= m3_p[60] ? 60'(-m3_p) : m3_p[59:0];
      m3_rho_q <= 60'(m2_rhi_q + 61'(m2_rlo_q[60:30]));

      m4_zlo_q <= 61'(m3_qm_q[29:0]) * 61'(m3_tr_q.sl);
      m4_zhi_q <= 61'(m3_qm_q[59:30]) * 61'(m3_tr_q.sl);
      m4_xlo_q <= 61'(m3_rho_q[29:0]) * 61'(m3_tr_q.co);
      m4_xhi_q <= 61'(m3_rho_q[59:30]) * 61'(m3_tr_q.co);
      m4_ylo_q <= 61'(m3_rho_q[29:0]) * 61'(m3_tr_q.so);
      m4_yhi_q <= 61'(m3_rho_q[59:30]) * 61'(m3_tr_q.so);

      m5_v_q[0] <= 60'(m4_xhi_q + 61'(m4_xlo_q[60:30]));
      m5_v_q[1] <= 60'(m4_yhi_q + 61'(m4_ylo_q[60:30]));
      m5_v_q[2] <= 60'(m4_zhi_q + 61'(m4_zlo_q[60:30]));

      for (int i = 0; i < 3; i++) begin
        m6_ll_q[i] <= 60'(m5_v_q[i][29:0]) * 60'(m5_v_q[i][29:0]);
        m6_hl_q[i] <= 60'(m5_v_q[i][59:30]) * 60'(m5_v_q[i][29:0]);
        m6_hh_q[i] <= 60'(m5_v_q[i][59:30]) * 60'(m5_v_q[i][59:30]);
        m7_sq_q[i] <= {m6_hh_q[i], 60'b0} + 120'({m6_hl_q[i], 31'b0}) + 120'(m6_ll_q[i]);
      end

      m8_r2_q <= 122'(m7_sq_q[0]) + 122'(m7_sq_q[1]) + 122'(m7_sq_q[2]);

      gdv_q[0].sat <= (m8_r2_q == '0) || (m8_r2_q <= 122'(gm_sh));
      gdv_q[0].d   <= m8_r2_q;
      gdv_q[0].r   <= 122'(gm_sh);
      gdv_q[0].q   <= '0;
    end
  end

  for (genvar k = 0; k < GDIV_STEPS; k++) begin : g_gdv
    always_ff @(posedge clk_i) begin
      if (adv) gdv_q[k+1] <= gdv_step(gdv_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= gdv_q[GDIV_STEPS].sat ? GRAVITY_MAX : gdv_q[GDIV_STEPS].q;
      m_axis_tuser <= gdv_q[GDIV_STEPS].sat;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[N_ST-1] && !m_axis_tready) |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == GRAVITY_MAX))
    else $error("saturated result not at maximum");

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_ISQ+ISQRT_STEPS] |-> (isq_q[ISQRT_STEPS].r != '0))
    else $error("square root of denominator is zero");

  a_ndiv_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_NDV+NDIV_STEPS] |-> (ndv_q[NDIV_STEPS].r < ndv_q[NDIV_STEPS].s))
    else $error("radius divider remainder out of range");

  a_gdiv_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_GDV+GDIV_STEPS] && !gdv_q[GDIV_STEPS].sat)
      |-> (gdv_q[GDIV_STEPS].r < gdv_q[GDIV_STEPS].d))
    else $error("gravity divider remainder out of range");

endmodule
`default_nettype wire
